@@ rtl/flpw_pkg.sv @@
package flpw_pkg;

  localparam int unsigned NUM_FRAMES        = 64;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned STORE_WORDS       = NUM_FRAMES * ENTRIES_PER_TABLE;

  localparam int unsigned IDX_W   = $clog2(ENTRIES_PER_TABLE);
  localparam int unsigned FRAME_W = $clog2(NUM_FRAMES);
  localparam int unsigned ADDR_W  = FRAME_W + IDX_W;

  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned OFS_W   = 12;
  localparam int unsigned PFN_W   = ENTRY_W - OFS_W;
  localparam int unsigned VA_W    = 48;
  localparam int unsigned SLOT_W  = 15;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ROOT_W  = 6;
  localparam int unsigned LVL_W   = 2;

  localparam logic [LVL_W-1:0] LVL_TOP  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_LEAF = 2'd3;

  // Entry attribute bits
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_WRITE   = 1;
  localparam int unsigned BIT_USER    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 2'd0,
    OP_TRANSLATE = 2'd1,
    OP_CHECK     = 2'd2
  } op_e;

  // Outcome of examining one fetched table entry
  typedef struct packed {
    logic                fail;
    logic                done;
    logic                ok;
    logic [ENTRY_W-1:0]  phys;
    logic [ADDR_W-1:0]   next_addr;
  } step_t;

  function automatic logic [IDX_W-1:0] va_index(logic [VA_W-1:0] va, logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic frame_in_range(logic [PFN_W-1:0] pfn);
    return pfn < PFN_W'(NUM_FRAMES);
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(logic [PFN_W-1:0] pfn, logic [IDX_W-1:0] idx);
    return {pfn[FRAME_W-1:0], idx};
  endfunction

endpackage

@@ rtl/flpw_req_if.sv @@
interface flpw_req_if;
  import flpw_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [VA_W-1:0]     virt_addr;
  logic                need_write;
  logic [SLOT_W-1:0]   entry_slot;
  logic [ENTRY_W-1:0]  entry_word;

  modport source (
    output valid, op, virt_addr, need_write, entry_slot, entry_word,
    input  ready
  );

  modport sink (
    input  valid, op, virt_addr, need_write, entry_slot, entry_word,
    output ready
  );
endinterface

@@ rtl/flpw_rsp_if.sv @@
interface flpw_rsp_if;
  import flpw_pkg::*;

  logic                valid;
  logic                ready;
  logic                ok;
  logic [ENTRY_W-1:0]  phys_addr;

  modport source (
    output valid, ok, phys_addr,
    input  ready
  );

  modport sink (
    input  valid, ok, phys_addr,
    output ready
  );
endinterface

@@ rtl/flpw_ram.sv @@
module flpw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/flpw_walk_unit.sv @@
module flpw_walk_unit (
  input  logic [flpw_pkg::ENTRY_W-1:0] entry_i,
  input  logic [flpw_pkg::LVL_W-1:0]   lvl_i,
  input  logic [flpw_pkg::VA_W-1:0]    va_i,
  input  logic                         is_check_i,
  input  logic                         need_write_i,
  output flpw_pkg::step_t              step_o
);
  import flpw_pkg::*;

  logic              pass;
  logic              last;
  logic [PFN_W-1:0]  pfn;
  logic [LVL_W-1:0]  lvl_next;

  assign pfn      = entry_i[ENTRY_W-1:OFS_W];
  assign last     = lvl_i == LVL_LEAF;
  assign lvl_next = lvl_i + 2'd1;
  // present always required, user only on an access check
  assign pass     = entry_i[BIT_PRESENT] && (!is_check_i || entry_i[BIT_USER]);

  always_comb begin
    step_o.fail      = !pass || (!last && !frame_in_range(pfn));
    step_o.done      = step_o.fail || last;
    step_o.ok        = pass && last && (!is_check_i || !need_write_i || entry_i[BIT_WRITE]);
    step_o.phys      = (pass && last && !is_check_i) ? {pfn, va_i[OFS_W-1:0]} : '0;
    step_o.next_addr = make_addr(pfn, va_index(va_i, lvl_next));
  end

endmodule

@@ rtl/four_level_page_walker.sv @@
// A write or an unknown op goes into the output register at its transfer if that register is free.
// A translate or check reads the top level on accept, then examines one table level per step.
// A walk is bounded by four dependent reads of the single-port entry store with registered
// read data, and no new request is taken until it ends; one write per cycle while the output is free.
// Reset: the store is cleared one word a cycle, all 32768 words (STORE_WORDS), with req ready
// low meanwhile; root_frame resets to 0 and may be written during the clear.
module four_level_page_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [flpw_pkg::ROOT_W-1:0] cfg_data_i,
  flpw_req_if.sink                    req_i,
  flpw_rsp_if.source                  rsp_o
);
  import flpw_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [ROOT_W-1:0]   root_q;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [VA_W-1:0]     va_q;
  logic                check_q;
  logic                need_write_q;
  logic                out_valid_q, out_valid_d;
  logic                out_ok_q, out_ok_d;
  logic [ENTRY_W-1:0]  out_phys_q, out_phys_d;
  logic                hold_ok_q;
  logic [ENTRY_W-1:0]  hold_phys_q;

  logic                accept;
  logic                out_free;
  logic                in_walk;
  logic                slot_ok;
  logic                root_ok;
  logic [PFN_W-1:0]    root_pfn;
  logic                fin;
  logic                fin_ok;
  logic [ENTRY_W-1:0]  fin_phys;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  step_t               step;

  assign req_i.ready = state_q == ST_IDLE;
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign in_walk     = (req_i.op == OP_TRANSLATE) || (req_i.op == OP_CHECK);
  assign slot_ok     = 32'(req_i.entry_slot) < STORE_WORDS;
  assign root_pfn    = PFN_W'(root_q);
  assign root_ok     = frame_in_range(root_pfn);

  flpw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  flpw_walk_unit u_walk (
    .entry_i      (ram_rdata),
    .lvl_i        (lvl_q),
    .va_i         (va_q),
    .is_check_i   (check_q),
    .need_write_i (need_write_q),
    .step_o       (step)
  );

  // Store port: clear sweep, entry write, or a table read (top level on accept, else the next level)
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = step.next_addr;
    ram_wdata = req_i.entry_word;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        if (req_i.op == OP_WRITE) begin
          ram_we   = accept && slot_ok;
          ram_addr = ADDR_W'(req_i.entry_slot);
        end else begin
          ram_addr = make_addr(root_pfn, va_index(req_i.virt_addr, LVL_TOP));
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    fin      = 1'b0;
    fin_ok   = 1'b0;
    fin_phys = '0;
    case (state_q)
      ST_IDLE: begin
        fin    = accept && (!in_walk || !root_ok);
        fin_ok = (req_i.op == OP_WRITE) && slot_ok;
      end
      ST_WALK: begin
        fin      = step.done;
        fin_ok   = step.ok;
        fin_phys = step.phys;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    lvl_d   = lvl_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == ADDR_W'(STORE_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (fin) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end else if (accept) begin
          state_d = ST_WALK;
          lvl_d   = LVL_TOP;
        end
      end
      ST_WALK: begin
        if (fin) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end else begin
          lvl_d = lvl_q + 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_ok_d    = out_ok_q;
    out_phys_d  = out_phys_q;
    if (out_free && fin) begin
      out_valid_d = 1'b1;
      out_ok_d    = fin_ok;
      out_phys_d  = fin_phys;
    end else if (out_free && state_q == ST_HOLD) begin
      out_valid_d = 1'b1;
      out_ok_d    = hold_ok_q;
      out_phys_d  = hold_phys_q;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      lvl_q       <= LVL_TOP;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        root_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_ok_q   <= out_ok_d;
    out_phys_q <= out_phys_d;
    if (accept) begin
      va_q         <= req_i.virt_addr;
      check_q      <= req_i.op == OP_CHECK;
      need_write_q <= req_i.need_write;
    end
    // park a finished result while the output register is still occupied
    if (fin && !out_free) begin
      hold_ok_q   <= fin_ok;
      hold_phys_q <= fin_phys;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.ok        = out_ok_q;
  assign rsp_o.phys_addr = out_phys_q;

endmodule

@@ rtl/flpw_checker.sv @@
module flpw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic [flpw_pkg::OP_W-1:0]    req_op_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic                         rsp_ok_i,
  input logic [flpw_pkg::ENTRY_W-1:0] rsp_phys_i
);
  import flpw_pkg::*;

  logic req_xfer;
  logic out_free;

  assign req_xfer = req_valid_i && req_ready_i;
  assign out_free = !rsp_valid_i || rsp_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_phys_i) && $stable(rsp_ok_i))
    else $error("response dropped or changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ok_i |-> rsp_phys_i == '0)
    else $error("failed result carries a nonzero address");

  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer && out_free && req_op_i != OP_TRANSLATE && req_op_i != OP_CHECK |=> rsp_valid_i)
    else $error("write result not registered the cycle after transfer");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer && (req_op_i == OP_TRANSLATE || req_op_i == OP_CHECK) |=> !rsp_valid_i || !req_ready_i
    || $past(rsp_valid_i && !rsp_ready_i) == 1'b0)
    else $error("walk accepted a new request without a result in flight");

endmodule

bind four_level_page_walker flpw_checker u_flpw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_op_i    (req_i.op),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_ok_i    (rsp_o.ok),
  .rsp_phys_i  (rsp_o.phys_addr)
);

@@ tb/four_level_page_walker_tb.sv @@
`timescale 1ns / 100ps

module four_level_page_walker_tb;
  import flpw_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Attribute patterns for the low three entry bits: user, writable, present
  localparam logic [2:0] FL_PUW = 3'b111;
  localparam logic [2:0] FL_PU  = 3'b101;
  localparam logic [2:0] FL_P   = 3'b001;
  localparam logic [2:0] FL_UW  = 3'b110;

  typedef struct packed {
    logic                drain;
    logic [OP_W-1:0]     op;
    logic [VA_W-1:0]     va;
    logic                need_write;
    logic [SLOT_W-1:0]   slot;
    logic [ENTRY_W-1:0]  word;
  } walk_req_t;

  typedef struct packed {
    logic                ok;
    logic [ENTRY_W-1:0]  phys;
  } walk_rsp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [ROOT_W-1:0]   cfg_data_i;

  flpw_req_if req_if ();
  flpw_rsp_if rsp_if ();

  four_level_page_walker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  // Mirror of the block's state
  logic [ENTRY_W-1:0]  pte_mirror [STORE_WORDS];
  logic [ROOT_W-1:0]   root_mirror;

  walk_req_t           req_backlog [$];
  walk_rsp_t           pending_rsp [$];
  logic [VA_W-1:0]     va_pool [$];

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  logic drain_next = 1'b0;

  int n_errors = 0;
  int n_queued = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_xlate_hit = 0;
  int n_xlate_miss = 0;
  int n_check_pass = 0;
  int n_check_fail = 0;
  int n_other = 0;

  walk_req_t drv_item;
  walk_rsp_t mon_want;

  task automatic report_mismatch(input string what, input logic [ENTRY_W-1:0] got,
                                 input logic [ENTRY_W-1:0] want);
    if (n_errors < 40)
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Apply one request to the mirror and return the response it must produce
  function automatic walk_rsp_t walk_outcome(walk_req_t r);
    walk_rsp_t          res;
    logic [PFN_W-1:0]   frame;
    logic [ENTRY_W-1:0] e;
    logic [IDX_W-1:0]   idx;
    logic               fail;
    int                 lvl;
    res = '0;
    if (r.op == OP_WRITE) begin
      if (r.slot < STORE_WORDS) begin
        pte_mirror[r.slot] = r.word;
        res.ok = 1'b1;
      end
      n_writes++;
    end else if (r.op == OP_TRANSLATE || r.op == OP_CHECK) begin
      frame = PFN_W'(root_mirror);
      fail = 1'b0;
      e = '0;
      for (lvl = 0; lvl < 4; lvl++) begin
        if (!fail) begin
          idx = r.va[39 - 9 * lvl +: 9];
          if (frame >= NUM_FRAMES) begin
            fail = 1'b1;
          end else begin
            e = pte_mirror[{frame[FRAME_W-1:0], idx}];
            if (!e[BIT_PRESENT] || (r.op == OP_CHECK && !e[BIT_USER]))
              fail = 1'b1;
            frame = e[ENTRY_W-1:OFS_W];
          end
        end
      end
      if (r.op == OP_TRANSLATE) begin
        if (!fail) begin
          res.ok = 1'b1;
          res.phys = {e[ENTRY_W-1:OFS_W], r.va[OFS_W-1:0]};
          n_xlate_hit++;
        end else begin
          n_xlate_miss++;
        end
      end else begin
        // writable bit matters on the leaf only
        res.ok = !fail && (!r.need_write || e[BIT_WRITE]);
        if (res.ok) n_check_pass++;
        else n_check_fail++;
      end
    end else begin
      n_other++;
    end
    return res;
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready)
        pending_rsp.push_back(walk_outcome('{drain: 1'b0, op: req_if.op, va: req_if.virt_addr,
                                             need_write: req_if.need_write,
                                             slot: req_if.entry_slot,
                                             word: req_if.entry_word}));
      if (!req_if.valid || req_if.ready) begin
        if (req_backlog.size() != 0 && !(req_backlog[0].drain && pending_rsp.size() != 0)
            && $urandom_range(99) >= send_idle_pct) begin
          drv_item = req_backlog.pop_front();
          req_if.valid      <= 1'b1;
          req_if.op         <= drv_item.op;
          req_if.virt_addr  <= drv_item.va;
          req_if.need_write <= drv_item.need_write;
          req_if.entry_slot <= drv_item.slot;
          req_if.entry_word <= drv_item.word;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected response", {63'd0, rsp_if.ok}, rsp_if.phys_addr);
        end else begin
          mon_want = pending_rsp.pop_front();
          if (rsp_if.ok !== mon_want.ok)
            report_mismatch("ok", {63'd0, rsp_if.ok}, {63'd0, mon_want.ok});
          if (rsp_if.phys_addr !== mon_want.phys)
            report_mismatch("phys_addr", rsp_if.phys_addr, mon_want.phys);
          n_checked++;
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  function automatic logic [ENTRY_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VA_W-1:0] rand_va();
    return VA_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ENTRY_W-1:0] tbl_entry(input logic [PFN_W-1:0] frame,
                                                   input logic [2:0] flags);
    return {frame, 9'($urandom), flags};
  endfunction

  task automatic queue_req(input logic [OP_W-1:0] op, input logic [VA_W-1:0] va,
                           input logic nw, input logic [SLOT_W-1:0] slot,
                           input logic [ENTRY_W-1:0] word);
    req_backlog.push_back('{drain: drain_next, op: op, va: va, need_write: nw,
                            slot: slot, word: word});
    drain_next = 1'b0;
    n_queued++;
  endtask

  task automatic queue_write(input logic [SLOT_W-1:0] slot, input logic [ENTRY_W-1:0] word);
    queue_req(OP_WRITE, rand_va(), 1'($urandom), slot, word);
  endtask

  task automatic queue_access(input logic [VA_W-1:0] va);
    queue_req($urandom_range(1) ? OP_TRANSLATE : OP_CHECK, va, 1'($urandom),
              SLOT_W'($urandom), rand_word());
  endtask

  // Lay down up to four entries that map the page holding va, stopping at an out-of-range frame
  task automatic build_chain(input logic [VA_W-1:0] va);
    logic [PFN_W-1:0]   frame;
    logic [PFN_W-1:0]   nxt;
    logic [ENTRY_W-1:0] word;
    logic [2:0]         fl;
    int                 lvl;
    int                 pick;
    frame = PFN_W'(root_mirror);
    nxt = '0;
    for (lvl = 0; lvl < 4 && frame < NUM_FRAMES; lvl++) begin
      pick = $urandom_range(11);
      fl = (pick == 0) ? 3'($urandom) : (pick == 1) ? FL_PU : FL_PUW;
      if (lvl == 3) begin
        word = rand_word();
        word[2:0] = fl;
      end else begin
        nxt = ($urandom_range(24) == 0) ? PFN_W'({$urandom, $urandom})
                                        : PFN_W'($urandom_range(NUM_FRAMES - 1));
        word = tbl_entry(nxt, fl);
      end
      queue_write({frame[FRAME_W-1:0], va[39 - 9 * lvl +: 9]}, word);
      frame = nxt;
    end
  endtask

  task automatic run_phase(input int n_items);
    int               start;
    int               pick;
    logic             drained;
    logic [VA_W-1:0]  va;
    start = n_queued;
    drained = 1'b0;
    while (n_queued - start < n_items) begin
      if (!drained && n_queued - start >= n_items / 2) begin
        drain_next = 1'b1;
        drained = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        va = rand_va();
        build_chain(va);
        va_pool.push_back(va);
        if (va_pool.size() > 48) void'(va_pool.pop_front());
        repeat ($urandom_range(1, 5))
          queue_access({va[VA_W-1:OFS_W], 12'($urandom)});
      end else if (pick < 75 && va_pool.size() != 0) begin
        va = va_pool[$urandom_range(va_pool.size() - 1)];
        queue_access({va[VA_W-1:OFS_W], 12'($urandom)});
      end else if (pick < 85) begin
        queue_write(SLOT_W'($urandom), rand_word());
      end else if (pick < 95) begin
        queue_access(rand_va());
      end else begin
        queue_req(OP_UNUSED, rand_va(), 1'($urandom), SLOT_W'($urandom), rand_word());
      end
    end
  endtask

  // Hold until every request has gone through and its response has come back
  task automatic wait_drained();
    while (req_backlog.size() != 0 || pending_rsp.size() != 0 || req_if.valid)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_root(input logic [ROOT_W-1:0] r);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    root_mirror = r;
  endtask

  initial begin
    foreach (pte_mirror[i]) pte_mirror[i] = '0;
    root_mirror = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.op = OP_WRITE;
    req_if.virt_addr = '0;
    req_if.need_write = 1'b0;
    req_if.entry_slot = '0;
    req_if.entry_word = '0;
    rsp_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_root(6'd0);

    // Empty store, unknown op
    queue_req(OP_TRANSLATE, '0, 1'b0, '0, '0);
    queue_req(OP_CHECK, '0, 1'b1, '0, '0);
    queue_req(OP_UNUSED, '1, 1'b1, '1, '1);
    // Lowest indices, leaf with every bit set
    queue_write({6'd0, 9'd0}, tbl_entry(52'd1, FL_PUW));
    queue_write({6'd1, 9'd0}, tbl_entry(52'd2, FL_PUW));
    queue_write({6'd2, 9'd0}, tbl_entry(52'd3, FL_PUW));
    queue_write({6'd3, 9'd0}, '1);
    queue_req(OP_TRANSLATE, 48'h0000_0000_0FFF, 1'b0, '0, '0);
    queue_req(OP_CHECK, 48'h0000_0000_0FFF, 1'b1, '0, '0);
    // Highest indices through the top frame; one table lacks the user bit
    queue_write({6'd0, 9'd511}, tbl_entry(52'd63, FL_PU));
    queue_write({6'd63, 9'd511}, tbl_entry(52'd62, FL_P));
    queue_write({6'd62, 9'd511}, tbl_entry(52'd61, FL_PUW));
    queue_write({6'd61, 9'd511}, 64'h8000_0000_0000_0005);
    queue_req(OP_TRANSLATE, '1, 1'b0, '0, '0);
    queue_req(OP_CHECK, '1, 1'b0, '0, '0);
    // Table pointer past the end of the store
    queue_write({6'd0, 9'd1}, tbl_entry(52'd64, FL_PUW));
    queue_req(OP_TRANSLATE, 48'h0080_0000_0123, 1'b0, '0, '0);
    // Leaf without the writable bit
    queue_write({6'd3, 9'd1}, 64'h0000_1234_5678_9005);
    queue_req(OP_CHECK, 48'h0000_0000_1ABC, 1'b1, '0, '0);
    queue_req(OP_CHECK, 48'h0000_0000_1ABC, 1'b0, '0, '0);
    queue_req(OP_TRANSLATE, 48'h0000_0000_1ABC, 1'b0, '0, '0);
    // Third level not present
    queue_write({6'd2, 9'd0}, tbl_entry(52'd3, FL_UW));
    queue_req(OP_TRANSLATE, 48'h0000_0000_0FFF, 1'b0, '0, '0);
    queue_write(SLOT_W'(STORE_WORDS - 1), '1);
    wait_drained();

    set_root(6'd63);
    run_phase(360);
    wait_drained();

    send_idle_pct = 77;
    set_root(ROOT_W'($urandom_range(1, 62)));
    run_phase(360);
    wait_drained();

    send_idle_pct = 0;
    rsp_stall_pct = 77;
    set_root(6'd0);
    run_phase(360);
    wait_drained();

    send_idle_pct = 23;
    rsp_stall_pct = 23;
    set_root(ROOT_W'($urandom_range(1, 62)));
    run_phase(360);
    wait_drained();

    if (pending_rsp.size() != 0)
      report_mismatch("responses still outstanding", 64'(pending_rsp.size()), '0);
    $display("%0d requests, %0d responses checked: %0d writes, %0d other ops",
             n_queued, n_checked, n_writes, n_other);
    $display("translations %0d hit / %0d missed, access checks %0d passed / %0d refused",
             n_xlate_hit, n_xlate_miss, n_check_pass, n_check_fail);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Covers the store clear after reset plus every phase at its slowest
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
